[rtl/core/sector_cache_clock_controller_macros.svh]
// Assertion macros used by the sector cache controller back end.
// No dependencies; include by bare file name.
`ifndef SECTOR_CACHE_CLOCK_CONTROLLER_MACROS_SVH
`define SECTOR_CACHE_CLOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sccc assertion failed");

// Next-cycle implication, disabled during reset.
`define SCCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sccc assertion failed");

`endif

[rtl/core/sccc_pkg.sv]
// Package for the sector cache controller: sizes, request codes, payload types.
// No dependencies.
`timescale 1ns / 1ps

package sccc_pkg;

    localparam int ENTRIES     = 64;
    localparam int SECTOR_BITS = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int OUT_IDX_W   = 6;
    localparam int SEC_W       = 32;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [ENTRIES-1:0]     t_vec;
    typedef logic [SECTOR_BITS-1:0] t_tag;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [SEC_W-1:0] sector;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 writeback_needed;
        logic [SEC_W-1:0]     writeback_sector;
        logic                 fetch_needed;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic flush;
        logic write;
        t_tag sector;
    } t_cmd;

    // Index of the lowest set bit; zero when none is set.
    function automatic t_idx lowest_set(input t_vec v);
        t_idx r;
        r = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

    // Bits strictly below idx.
    function automatic t_vec below_mask(input t_idx idx);
        t_vec m;
        for (int i = 0; i < ENTRIES; i++) begin
            m[i] = (t_idx'(i) < idx);
        end
        return m;
    endfunction

endpackage

[rtl/core/sccc_front.sv]
// Front end: accepts requests, drops REQ_NONE codes, queues commands.
// Depends on sccc_pkg.
`timescale 1ns / 1ps

module sccc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sccc_pkg::t_in  i_in,
    output logic           o_cmd_valid,
    input  logic           i_cmd_pop,
    output sccc_pkg::t_cmd o_cmd
);

    sccc_pkg::t_cmd r_q [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    logic           accept, push, pop;
    sccc_pkg::t_cmd cmd;

    assign o_in_stall  = (r_count == 2'd2);
    assign accept      = i_in_valid && !o_in_stall;
    assign push        = accept && (i_in.req_type != sccc_pkg::REQ_NONE);
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        cmd.flush  = (i_in.req_type == sccc_pkg::REQ_FLUSH);
        cmd.write  = (i_in.req_type == sccc_pkg::REQ_WRITE);
        cmd.sector = sccc_pkg::SECTOR_BITS'(i_in.sector);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/sccc_back.sv]
// Back end: tag memory scan, clock victim selection, refill and flush walk.
// Depends on sccc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sector_cache_clock_controller_macros.svh"

module sccc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  sccc_pkg::t_cmd i_cmd,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sccc_pkg::t_out o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_FLSH = 3'd3;
    localparam logic [2:0] S_FLRD = 3'd4;
    localparam logic [2:0] S_SEND = 3'd5;

    localparam sccc_pkg::t_idx LAST_IDX = sccc_pkg::IDX_W'(sccc_pkg::ENTRIES - 1);

    sccc_pkg::t_tag r_mem [sccc_pkg::ENTRIES];
    sccc_pkg::t_tag r_rd_data;
    sccc_pkg::t_idx rd_addr;

    logic [2:0]     r_state, n_state;
    sccc_pkg::t_vec r_valid, n_valid, r_dirty, n_dirty, r_ref, n_ref;
    sccc_pkg::t_idx r_cnt, n_cnt, r_cmp_idx, n_cmp_idx, r_vic, n_vic;
    logic           r_cmp_vld, n_cmp_vld, r_issued, n_issued;
    logic           r_write, n_write, r_flush, n_flush, r_flast, n_flast;
    sccc_pkg::t_tag r_sector, n_sector;
    sccc_pkg::t_out r_res, n_res;
    logic           r_out_valid, n_out_valid;
    sccc_pkg::t_out r_out, n_out;

    logic           out_free, mem_we, wb;
    sccc_pkg::t_vec cand, vd;
    sccc_pkg::t_idx vic, fidx;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign cand        = ~(r_valid & r_ref);
    assign vic         = sccc_pkg::lowest_set(cand);
    assign vd          = r_valid & r_dirty;
    assign fidx        = sccc_pkg::lowest_set(vd);
    assign wb          = r_valid[r_vic] && r_dirty[r_vic];

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_ref       = r_ref;
        n_cnt       = r_cnt;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = 1'b0;
        n_issued    = r_issued;
        n_vic       = r_vic;
        n_write     = r_write;
        n_flush     = r_flush;
        n_flast     = r_flast;
        n_sector    = r_sector;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        o_cmd_pop   = 1'b0;
        rd_addr     = r_cnt;
        mem_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_write   = i_cmd.write;
                    n_sector  = i_cmd.sector;
                    n_cnt     = '0;
                    n_issued  = 1'b0;
                    n_state   = i_cmd.flush ? S_FLSH : S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue tag reads in order; each is compared in the next cycle.
                if (!r_issued) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_cnt;
                    if (r_cnt == LAST_IDX) begin
                        n_issued = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    rd_addr = vic;
                end
                if (r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_sector)) begin
                    n_ref[r_cmp_idx] = 1'b1;
                    if (r_write) begin
                        n_dirty[r_cmp_idx] = 1'b1;
                    end
                    n_res         = '0;
                    n_res.hit     = 1'b1;
                    n_res.entry_index = sccc_pkg::OUT_IDX_W'(r_cmp_idx);
                    n_res.last    = 1'b1;
                    n_flush       = 1'b0;
                    n_cmp_vld     = 1'b0;
                    n_state       = S_SEND;
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    // Miss: clear reference bits passed by the clock hand.
                    n_vic = vic;
                    if (cand == '0) begin
                        n_ref = '0;
                    end else begin
                        n_ref = r_ref & ~sccc_pkg::below_mask(vic);
                    end
                    n_cmp_vld = 1'b0;
                    n_state   = S_FILL;
                end
            end
            S_FILL: begin
                mem_we                 = 1'b1;
                n_valid[r_vic]         = 1'b1;
                n_ref[r_vic]           = 1'b1;
                n_dirty[r_vic]         = r_write;
                n_res                  = '0;
                n_res.entry_index      = sccc_pkg::OUT_IDX_W'(r_vic);
                n_res.writeback_needed = wb;
                n_res.writeback_sector = wb ? sccc_pkg::SEC_W'(r_rd_data) : '0;
                n_res.fetch_needed     = 1'b1;
                n_res.last             = 1'b1;
                n_flush                = 1'b0;
                n_state                = S_SEND;
            end
            S_FLSH: begin
                if (vd == '0) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_flush    = 1'b0;
                    n_state    = S_SEND;
                end else begin
                    rd_addr       = fidx;
                    n_vic         = fidx;
                    n_dirty[fidx] = 1'b0;
                    n_flast       = ((vd & ~(sccc_pkg::t_vec'(1) << fidx)) == '0);
                    n_state       = S_FLRD;
                end
            end
            S_FLRD: begin
                n_res                  = '0;
                n_res.entry_index      = sccc_pkg::OUT_IDX_W'(r_vic);
                n_res.writeback_needed = 1'b1;
                n_res.writeback_sector = sccc_pkg::SEC_W'(r_rd_data);
                n_res.last             = r_flast;
                n_flush                = !r_flast;
                n_state                = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_flush ? S_FLSH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[r_vic] <= r_sector;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sector  <= n_sector;
        r_res     <= n_res;
        r_out     <= n_out;
        r_vic     <= n_vic;
        r_cmp_idx <= n_cmp_idx;
        r_write   <= n_write;
        r_flast   <= n_flast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_ref       <= '0;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_issued    <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_ref       <= n_ref;
            r_cnt       <= n_cnt;
            r_cmp_vld   <= n_cmp_vld;
            r_issued    <= n_issued;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    `SCCC_ASSERT_NOW(a_fill_after_scan, i_clk, i_rst_n, r_state == S_FILL, $past(r_state) == S_SCAN)
    `SCCC_ASSERT_NEXT(a_fill_sets_entry, i_clk, i_rst_n, r_state == S_FILL, r_valid[r_vic] && r_ref[r_vic])
    `SCCC_ASSERT_NOW(a_flush_cleans, i_clk, i_rst_n, r_state == S_FLRD, !r_dirty[r_vic] && r_valid[r_vic])

endmodule

[rtl/core/sector_cache_clock_controller.sv]
// Top level of the sector cache tag controller with clock replacement.
// Depends on sccc_pkg, sccc_front and sccc_back.
//
// Usage: requests enter on i_in (req_type, sector) under i_in_valid/o_in_stall
// and results leave on o_out under o_out_valid/i_out_stall. A transaction is
// taken at a clock edge with valid high and stall low. Read and write give one
// result; flush gives one result per dirty entry, or one empty result, and
// marks the final one with last. req_type 3 is dropped without a result.
// The front takes a request each cycle while its two-deep command queue is not full.
// Read or write: the tag memory is read one entry per cycle in index order.
// A hit on entry k ends the scan there and gives its result; a miss scans
// every entry, reads the victim tag and refills it. Flush: each dirty entry
// passes S_FLSH, S_FLRD and S_SEND in turn, read on the single tag read port.
// Reset clears valid, dirty and reference bits, the queue and the output.
// A stalled result holds in the output register; the back end waits on it
// while the front keeps filling the queue until it is full.
`timescale 1ns / 1ps

module sector_cache_clock_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sccc_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sccc_pkg::t_out o_out
);

    logic           cmd_valid, cmd_pop;
    sccc_pkg::t_cmd cmd;

    sccc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    sccc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

[bench/tb.sv]
// Testbench for sector_cache_clock_controller: directed and random sector requests
// checked against an in-bench model of the tag, valid, dirty and reference state.
// Depends on sccc_pkg and the RTL of the controller.
`timescale 1ns / 1ps

module tb;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    sccc_pkg::t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    sccc_pkg::t_out o_out;

    sector_cache_clock_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // cache state mirror
    logic [31:0] tag_mirror [sccc_pkg::ENTRIES];
    logic [sccc_pkg::ENTRIES-1:0] valid_mirror;
    logic [sccc_pkg::ENTRIES-1:0] dirty_mirror;
    logic [sccc_pkg::ENTRIES-1:0] ref_mirror;

    sccc_pkg::t_out pending_results [$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    logic [31:0] recent_sectors [$];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic sccc_pkg::t_out make_result(logic hit, int idx, logic wb,
                                                   logic [31:0] wsec, logic fetch,
                                                   logic last);
        sccc_pkg::t_out r;
        r.hit = hit;
        r.entry_index = idx[sccc_pkg::OUT_IDX_W-1:0];
        r.writeback_needed = wb;
        r.writeback_sector = wsec;
        r.fetch_needed = fetch;
        r.last = last;
        return r;
    endfunction

    // Update the mirror for one request and queue the results it causes.
    task automatic predict_request(sccc_pkg::t_in req);
        int victim;
        int n;
        int hit_idx;
        logic wb;
        logic [31:0] old;
        hit_idx = -1;
        victim = 0;
        n = 0;
        if (req.req_type == sccc_pkg::REQ_FLUSH) begin
            for (int i = 0; i < sccc_pkg::ENTRIES; i++) begin
                if (valid_mirror[i] && dirty_mirror[i]) begin
                    pending_results.push_back(make_result(1'b0, i, 1'b1, tag_mirror[i],
                                                          1'b0, 1'b0));
                    dirty_mirror[i] = 1'b0;
                    n++;
                end
            end
            if (n == 0) begin
                pending_results.push_back(make_result(1'b0, 0, 1'b0, '0, 1'b0, 1'b1));
            end else begin
                pending_results[$].last = 1'b1;
            end
        end else if (req.req_type != sccc_pkg::REQ_NONE) begin
            for (int i = 0; i < sccc_pkg::ENTRIES; i++) begin
                if (hit_idx < 0 && valid_mirror[i] && tag_mirror[i] == req.sector) begin
                    hit_idx = i;
                end
            end
            if (hit_idx >= 0) begin
                ref_mirror[hit_idx] = 1'b1;
                if (req.req_type == sccc_pkg::REQ_WRITE) begin
                    dirty_mirror[hit_idx] = 1'b1;
                end
                pending_results.push_back(make_result(1'b1, hit_idx, 1'b0, '0, 1'b0, 1'b1));
            end else begin
                victim = -1;
                for (int i = 0; i < sccc_pkg::ENTRIES; i++) begin
                    if (victim < 0) begin
                        if (!valid_mirror[i] || !ref_mirror[i]) begin
                            victim = i;
                        end else begin
                            ref_mirror[i] = 1'b0;
                        end
                    end
                end
                if (victim < 0) begin
                    victim = 0;
                end
                wb = valid_mirror[victim] && dirty_mirror[victim];
                old = wb ? tag_mirror[victim] : '0;
                tag_mirror[victim] = req.sector;
                valid_mirror[victim] = 1'b1;
                ref_mirror[victim] = 1'b1;
                dirty_mirror[victim] = (req.req_type == sccc_pkg::REQ_WRITE);
                pending_results.push_back(make_result(1'b0, victim, wb, old, 1'b1, 1'b1));
            end
        end
    endtask

    // Offer one transaction and hold it until accepted.
    task automatic send_request(logic [1:0] kind, logic [31:0] sector);
        sccc_pkg::t_in req;
        req.req_type = kind;
        req.sector = sector;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_request(req);
        if (recent_sectors.size() >= 96) begin
            void'(recent_sectors.pop_front());
        end
        recent_sectors.push_back(sector);
    endtask

    // Receiver: random stall, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        sccc_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %p", o_out);
                end
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r !== o_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %p, got %p", exp_r, o_out);
                    end
                end
            end
        end
    end

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sector();
        int r;
        r = $urandom_range(99);
        if (r < 55 && recent_sectors.size() > 0) begin
            return recent_sectors[$urandom_range(recent_sectors.size() - 1)];
        end else if (r < 85) begin
            return 32'($urandom_range(79));
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            return sccc_pkg::REQ_READ;
        end else if (r < 88) begin
            return sccc_pkg::REQ_WRITE;
        end else if (r < 95) begin
            return sccc_pkg::REQ_FLUSH;
        end
        return sccc_pkg::REQ_NONE;
    endfunction

    task automatic test_directed;
        send_request(sccc_pkg::REQ_FLUSH, 32'h0);                 // flush of a clean cache
        send_request(sccc_pkg::REQ_READ, 32'h0000_0000);
        send_request(sccc_pkg::REQ_WRITE, 32'hFFFF_FFFF);
        send_request(sccc_pkg::REQ_READ, 32'h0000_0000);          // read hit
        send_request(sccc_pkg::REQ_WRITE, 32'h0000_0000);         // write hit sets dirty
        send_request(sccc_pkg::REQ_NONE, 32'hA5A5_5A5A);          // dropped
        send_request(sccc_pkg::REQ_WRITE, 32'h5A5A_A5A5);
        send_request(sccc_pkg::REQ_FLUSH, 32'hFFFF_FFFF);
        send_request(sccc_pkg::REQ_FLUSH, 32'h1234_5678);         // nothing dirty left
        send_request(sccc_pkg::REQ_READ, 32'hAAAA_AAAA);
        send_request(sccc_pkg::REQ_WRITE, 32'h5555_5555);
        drain();
    endtask

    // Fill all entries referenced, then miss: full sweep takes entry 0.
    task automatic test_full_sweep;
        for (int i = 0; i < sccc_pkg::ENTRIES + 2; i++) begin
            send_request(sccc_pkg::REQ_WRITE, 32'h8000_0000 + 32'(i));
        end
        for (int i = 0; i < sccc_pkg::ENTRIES; i++) begin
            send_request(sccc_pkg::REQ_READ, 32'h8000_0000 + 32'(i));
        end
        send_request(sccc_pkg::REQ_WRITE, 32'h7000_0001);
        send_request(sccc_pkg::REQ_FLUSH, 32'h0);                 // many writebacks
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_request(pick_kind(), pick_sector());
        end
        drain();
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure;
        send_idle_pct = 0;
        hold_cycles <= 600;
        for (int i = 0; i < 12; i++) begin
            send_request(pick_kind(), pick_sector());
        end
        drain();
    endtask

    initial begin
        mismatches = 0;
        hold_cycles = 0;
        send_idle_pct = 33;
        recv_idle_pct = 56;
        valid_mirror = '0;
        dirty_mirror = '0;
        ref_mirror = '0;
        for (int i = 0; i < sccc_pkg::ENTRIES; i++) begin
            tag_mirror[i] = '0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_sweep();
        test_random(80);
        send_idle_pct = 56;
        recv_idle_pct = 33;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(70);
        test_backpressure();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("tb failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sccc_pkg.sv
rtl/core/sccc_front.sv
rtl/core/sccc_back.sv
rtl/core/sector_cache_clock_controller.sv
bench/tb.sv
